@@ hdl/msq_pkg.sv @@
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types and constants for the mode selectable stack/queue core.
// ----------------------------------------------------------------------------
package msq_pkg;

   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ELEM_W   = 32;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;
   localparam int ACTION_W = 2;
   localparam int MODE_W   = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_WALK   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD       = 2'd0,
      OP_FROM_LEFT  = 2'd1,
      OP_FROM_RIGHT = 2'd2,
      OP_LOAD       = 2'd3
   } cell_op_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } state_type;

   typedef struct packed {
      cell_op_type op;
      logic        at_tail;
      logic        at_fill;
   } cell_ctl_type;

endpackage

@@ hdl/msq_req_if.sv @@
// ----------------------------------------------------------------------------
// msq_req_if
// Request channel: action and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface msq_req_if;
   logic                              valid;
   logic                              ready;
   logic [msq_pkg::ACTION_W-1:0]      action;
   logic signed [msq_pkg::ELEM_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

@@ hdl/msq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// msq_rsp_if
// Response channel: element, count, status and last with valid/ready handshake.
// ----------------------------------------------------------------------------
interface msq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [msq_pkg::ELEM_W-1:0] element;
   logic [msq_pkg::COUNT_W-1:0]       count;
   logic [msq_pkg::STATUS_W-1:0]      status;
   logic                              last;

   modport source (output valid, output element, output count, output status,
                   output last, input ready);
   modport sink   (input valid, input element, input count, input status,
                   input last, output ready);
endinterface

@@ hdl/msq_cell.sv @@
// ----------------------------------------------------------------------------
// msq_cell
// One storage cell of the chain; shifts, rotates or loads one element.
// ----------------------------------------------------------------------------
module msq_cell (
   input  logic                         clock,
   input  msq_pkg::cell_ctl_type        ctl,
   input  logic [msq_pkg::ELEM_W-1:0]   left_in,
   input  logic [msq_pkg::ELEM_W-1:0]   right_in,
   input  logic [msq_pkg::ELEM_W-1:0]   wrap_in,
   input  logic [msq_pkg::ELEM_W-1:0]   load_in,
   output logic [msq_pkg::ELEM_W-1:0]   data_out
);

   logic [msq_pkg::ELEM_W-1:0] data_ff;
   logic [msq_pkg::ELEM_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         msq_pkg::OP_HOLD:       data_in = data_ff;
         msq_pkg::OP_FROM_LEFT:  data_in = left_in;
         msq_pkg::OP_FROM_RIGHT: data_in = ctl.at_tail ? wrap_in : right_in;
         msq_pkg::OP_LOAD:       data_in = ctl.at_fill ? load_in : data_ff;
         default:                data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

@@ hdl/mode_selectable_stack_queue_core.sv @@
// ----------------------------------------------------------------------------
// mode_selectable_stack_queue_core
// Bounded double-ended store built as a row of cells; mode picks the add and
// remove ends so the block acts as a stack or a queue.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  req     | in        | action, value
//  rsp     | out       | element, count, status, last
//  csr     | in        | order_mode write (csr_we, csr_wdata)
//
//  add, remove, clear and an empty walk give a single response; a walk of n
//  elements gives n results after the accepting cycle, as the chain rotates
//  one cell per cycle while the response register is free and is restored at the end. req is held
//  off during a walk and while the response register is full and not being
//  taken. reset is synchronous and clears count, mode, state and response
//  valid; cell contents are not reset.
module mode_selectable_stack_queue_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [msq_pkg::MODE_W-1:0]   csr_wdata,
   msq_req_if.sink                      req_bus,
   msq_rsp_if.source                    rsp_bus
);

   localparam int DEPTH = msq_pkg::DEPTH;
   localparam int CNT_W = msq_pkg::CNT_W;
   localparam int IDX_W = msq_pkg::IDX_W;
   localparam int EW    = msq_pkg::ELEM_W;

   logic [msq_pkg::MODE_W-1:0]     mode_ff;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               pos_ff, pos_in;
   msq_pkg::state_type             state_ff, state_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]                  rsp_elem_ff, rsp_elem_in;
   logic [CNT_W-1:0]               rsp_count_ff, rsp_count_in;
   msq_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [EW-1:0]                  cell_q [DEPTH];
   msq_pkg::cell_ctl_type          cell_ctl [DEPTH];
   msq_pkg::cell_op_type           op;
   logic [EW-1:0]                  head_left;
   logic [EW-1:0]                  tail_data;
   logic [IDX_W-1:0]               tail_idx;
   logic                           add_rear, rem_rear, out_free, accept;

   assign add_rear  = mode_ff[0];
   assign rem_rear  = mode_ff[1];
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign tail_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign tail_data = cell_q[tail_idx];
   assign req_bus.ready = (state_ff == msq_pkg::S_IDLE) && out_free;
   assign accept    = req_bus.valid && req_bus.ready;
   assign head_left = (state_ff == msq_pkg::S_WALK) ? tail_data : req_bus.value;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [EW-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = head_left;
      end else begin : g_mid_l
         assign left_v = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_q[i+1];
      end
      assign cell_ctl[i].op      = op;
      assign cell_ctl[i].at_tail = (CNT_W'(i + 1) == count_ff);
      assign cell_ctl[i].at_fill = (CNT_W'(i) == count_ff);

      msq_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .left_in  (left_v),
         .right_in (right_v),
         .wrap_in  (cell_q[0]),
         .load_in  (req_bus.value),
         .data_out (cell_q[i])
      );
   end

   always_comb begin
      op            = msq_pkg::OP_HOLD;
      count_in      = count_ff;
      pos_in        = pos_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_elem_in   = rsp_elem_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         msq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = '0;
               rsp_status_in = msq_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               case (req_bus.action)
                  msq_pkg::ACT_ADD: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = msq_pkg::ST_FULL;
                     end else begin
                        op       = add_rear ? msq_pkg::OP_LOAD : msq_pkg::OP_FROM_LEFT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  msq_pkg::ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = msq_pkg::ST_EMPTY;
                     end else begin
                        rsp_elem_in = rem_rear ? tail_data : cell_q[0];
                        op          = rem_rear ? msq_pkg::OP_HOLD : msq_pkg::OP_FROM_RIGHT;
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  msq_pkg::ACT_WALK: begin
                     pos_in = '0;
                     if (count_ff == '0) begin
                        rsp_status_in = msq_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = msq_pkg::S_WALK;
                     end
                  end
                  msq_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         msq_pkg::S_WALK: begin
            if (out_free) begin
               // rotate one cell; the row is back in place after count steps
               op            = add_rear ? msq_pkg::OP_FROM_LEFT : msq_pkg::OP_FROM_RIGHT;
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = add_rear ? tail_data : cell_q[0];
               rsp_count_in  = count_ff;
               rsp_status_in = msq_pkg::ST_OK;
               rsp_last_in   = (pos_ff + CNT_W'(1) == count_ff);
               pos_in        = pos_ff + CNT_W'(1);
               if (pos_ff + CNT_W'(1) == count_ff) begin
                  state_in = msq_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = msq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msq_pkg::S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_elem_ff   <= rsp_elem_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.element = rsp_elem_ff;
   assign rsp_bus.count   = msq_pkg::COUNT_W'(rsp_count_ff);
   assign rsp_bus.status  = rsp_status_ff;
   assign rsp_bus.last    = rsp_last_ff;

endmodule

@@ test/mode_selectable_stack_queue_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mode_selectable_stack_queue_core_test
// Self-checking bench for the stack/queue core. A short table of directed
// transactions covers the empty and full cases, value extremes and every
// order mode; random phases follow, each under its own mode and fill bias.
// A shadow copy of the store predicts every response, which is compared field
// by field while the sender runs in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module mode_selectable_stack_queue_core_test;

   localparam int DEPTH   = msq_pkg::DEPTH;
   localparam int IDX_W   = msq_pkg::IDX_W;
   localparam int ELEM_W  = msq_pkg::ELEM_W;
   localparam int COUNT_W = msq_pkg::COUNT_W;
   localparam int MODE_W  = msq_pkg::MODE_W;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [COUNT_W-1:0]       count;
      msq_pkg::status_type      status;
      logic                     last;
   } response_type;

   typedef struct packed {
      logic                mode_write;
      logic [MODE_W-1:0]   mode;
      msq_pkg::action_type act;
      logic [ELEM_W-1:0]   value;
      logic [5:0]          reps;
      logic                typed;
      logic [COUNT_W-1:0]  typed_count;
      msq_pkg::status_type typed_status;
   } directed_row_type;

   localparam int N_DIRECTED   = 22;
   localparam int RANDOM_ITEMS = 400;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [MODE_W-1:0] csr_wdata;

   msq_req_if req_bus ();
   msq_rsp_if rsp_bus ();

   mode_selectable_stack_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #10 clock = ~clock;

   // shadow of the store
   logic [ELEM_W-1:0]  shadow_slots [DEPTH];
   logic [IDX_W-1:0]   shadow_front;
   logic [COUNT_W-1:0] shadow_count;
   logic [MODE_W-1:0]  shadow_mode;

   response_type expected_responses [$];

   int error_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int full_seen      = 0;
   int empty_seen     = 0;
   int burst_left     = 0;
   int run_left       = 0;
   int stall_left     = 0;
   logic [3:0] modes_used = '0;

   // mode write, mode, action, value, reps, typed, count, status
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{1'b1, 2'd0, msq_pkg::ACT_ADD,    32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_WALK,   32'h0,        6'd1,  1'b1, 6'd0,  msq_pkg::ST_EMPTY},
      '{1'b0, 2'd0, msq_pkg::ACT_REMOVE, 32'h0,        6'd1,  1'b1, 6'd0,  msq_pkg::ST_EMPTY},
      '{1'b0, 2'd0, msq_pkg::ACT_CLEAR,  32'hffffffff, 6'd1,  1'b1, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'h80000000, 6'd1,  1'b1, 6'd1,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'h7fffffff, 6'd1,  1'b1, 6'd2,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'hffffffff, 6'd1,  1'b1, 6'd3,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'h00000001, 6'd1,  1'b1, 6'd4,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_WALK,   32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_REMOVE, 32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b1, 2'd3, msq_pkg::ACT_ADD,    32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_WALK,   32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_REMOVE, 32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b1, 2'd1, msq_pkg::ACT_ADD,    32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'h0,        6'd30, 1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'haaaaaaaa, 6'd1,  1'b1, 6'd32, msq_pkg::ST_FULL},
      '{1'b0, 2'd0, msq_pkg::ACT_WALK,   32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b1, 2'd2, msq_pkg::ACT_ADD,    32'h0,        6'd1,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_REMOVE, 32'h0,        6'd3,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_ADD,    32'h0,        6'd5,  1'b0, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_CLEAR,  32'h0,        6'd1,  1'b1, 6'd0,  msq_pkg::ST_OK},
      '{1'b0, 2'd0, msq_pkg::ACT_WALK,   32'h55555555, 6'd1,  1'b1, 6'd0,  msq_pkg::ST_EMPTY}
   };

   function automatic void predict_action(input msq_pkg::action_type act,
                                          input logic [ELEM_W-1:0] value);
      logic [IDX_W-1:0]   idx;
      logic [COUNT_W-1:0] off;
      logic [ELEM_W-1:0]  elem;
      case (act)
         msq_pkg::ACT_ADD: begin
            if (shadow_count >= DEPTH) begin
               expected_responses.push_back('{'0, shadow_count, msq_pkg::ST_FULL, 1'b1});
            end else begin
               if (shadow_mode[0]) begin
                  idx = shadow_front + shadow_count[IDX_W-1:0];
                  shadow_slots[idx] = value;
               end else begin
                  shadow_front = shadow_front - 1'b1;
                  shadow_slots[shadow_front] = value;
               end
               shadow_count = shadow_count + 1'b1;
               expected_responses.push_back('{'0, shadow_count, msq_pkg::ST_OK, 1'b1});
            end
         end
         msq_pkg::ACT_REMOVE: begin
            if (shadow_count == 0) begin
               expected_responses.push_back('{'0, shadow_count, msq_pkg::ST_EMPTY, 1'b1});
            end else begin
               if (shadow_mode[1]) begin
                  idx = shadow_front + shadow_count[IDX_W-1:0] - 1'b1;
                  elem = shadow_slots[idx];
               end else begin
                  elem = shadow_slots[shadow_front];
                  shadow_front = shadow_front + 1'b1;
               end
               shadow_count = shadow_count - 1'b1;
               expected_responses.push_back('{elem, shadow_count, msq_pkg::ST_OK, 1'b1});
            end
         end
         msq_pkg::ACT_WALK: begin
            if (shadow_count == 0) begin
               expected_responses.push_back('{'0, shadow_count, msq_pkg::ST_EMPTY, 1'b1});
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  off = COUNT_W'(shadow_mode[0] ? shadow_count - 1 - i : i);
                  idx = shadow_front + off[IDX_W-1:0];
                  expected_responses.push_back('{shadow_slots[idx], shadow_count,
                                                 msq_pkg::ST_OK,
                                                 (i == shadow_count - 1)});
               end
            end
         end
         default: begin
            shadow_count = '0;
            shadow_front = '0;
            expected_responses.push_back('{'0, shadow_count, msq_pkg::ST_OK, 1'b1});
         end
      endcase
   endfunction

   task automatic report(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // burst-mode sender, prediction at the accepting edge
   task automatic send_item(input msq_pkg::action_type act, input logic [ELEM_W-1:0] value);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 50 : $urandom_range(1, 12);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_action(act, value);
      items_sent++;
      burst_left--;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      wait_idle();
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_mode = m;
      modes_used[m] = 1'b1;
   endtask

   function automatic msq_pkg::action_type pick_action(input int bias);
      int r;
      r = $urandom_range(0, 99);
      case (bias)
         0: begin
            if (r < 70) return msq_pkg::ACT_ADD;
            if (r < 88) return msq_pkg::ACT_REMOVE;
            if (r < 96) return msq_pkg::ACT_WALK;
         end
         1: begin
            if (r < 25) return msq_pkg::ACT_ADD;
            if (r < 85) return msq_pkg::ACT_REMOVE;
            if (r < 96) return msq_pkg::ACT_WALK;
         end
         default: begin
            if (r < 45) return msq_pkg::ACT_ADD;
            if (r < 85) return msq_pkg::ACT_REMOVE;
            if (r < 97) return msq_pkg::ACT_WALK;
         end
      endcase
      return msq_pkg::ACT_CLEAR;
   endfunction

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'hffffffff;
         3: return 32'h00000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_response();
      response_type exp;
      if (expected_responses.size() == 0) begin
         report($sformatf("unexpected transaction element %0d count %0d",
                          rsp_bus.element, rsp_bus.count));
      end else begin
         exp = expected_responses.pop_front();
         results_seen++;
         if (exp.status == msq_pkg::ST_FULL) full_seen++;
         if (exp.status == msq_pkg::ST_EMPTY) empty_seen++;
         if (rsp_bus.element !== exp.element)
            report($sformatf("element %0d, expected %0d", rsp_bus.element, exp.element));
         if (rsp_bus.count !== exp.count)
            report($sformatf("count %0d, expected %0d", rsp_bus.count, exp.count));
         if (rsp_bus.status !== exp.status)
            report($sformatf("status %0d, expected %0d", rsp_bus.status, exp.status));
         if (rsp_bus.last !== exp.last)
            report($sformatf("last %0d, expected %0d", rsp_bus.last, exp.last));
      end
   endtask

   // receiver with its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_response();
         if (run_left == 0 && stall_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               run_left   = 60;
               stall_left = 0;
            end else begin
               run_left   = $urandom_range(1, 10);
               stall_left = $urandom_range(0, 8);
            end
         end
         if (run_left > 0) begin
            rsp_bus.ready <= 1'b1;
            run_left--;
         end else begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end
      end
   end

   initial begin
      #20ms;
      $display("timeout with %0d responses outstanding", expected_responses.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int random_sent;
      int phase;
      int bias;
      int phase_items;
      logic [MODE_W-1:0] m;
      random_sent = 0;
      phase       = 0;
      shadow_front = '0;
      shadow_count = '0;
      shadow_mode  = '0;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.action <= msq_pkg::ACT_ADD;
      req_bus.value  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode_write) begin
            write_mode(directed_rows[i].mode);
         end else begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
               send_item(directed_rows[i].act,
                         (directed_rows[i].reps > 1) ? $urandom : directed_rows[i].value);
               if (directed_rows[i].typed) begin
                  void'(expected_responses.pop_back());
                  expected_responses.push_back('{'0, directed_rows[i].typed_count,
                                                 directed_rows[i].typed_status, 1'b1});
               end
            end
         end
      end

      // random phases, each with its own mode and fill bias
      while (random_sent < RANDOM_ITEMS) begin
         m = (phase < 4) ? phase[MODE_W-1:0] : MODE_W'($urandom_range(0, 3));
         write_mode(m);
         bias = phase % 3;
         phase_items = $urandom_range(25, 45);
         for (int k = 0; k < phase_items; k++) begin
            send_item(pick_action(bias), pick_value());
            random_sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_responses.size() != 0)
         report($sformatf("%0d responses never arrived", expected_responses.size()));
      $display("run covered %0d transactions in %0d random phases, %0d responses checked",
               items_sent, phase, results_seen);
      $display("full responses %0d, empty responses %0d, modes used %b",
               full_seen, empty_seen, modes_used);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/msq_pkg.sv
hdl/msq_req_if.sv
hdl/msq_rsp_if.sv
hdl/msq_cell.sv
hdl/mode_selectable_stack_queue_core.sv
test/mode_selectable_stack_queue_core_test.sv
